/* rtl/core/rotation_matrix_to_euler_angles_defines.svh */
// Assertion macros shared by the RTL of the Euler angle block
`ifndef ROTATION_MATRIX_TO_EULER_ANGLES_DEFINES_SVH
`define ROTATION_MATRIX_TO_EULER_ANGLES_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during rst
`define RME_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rme assertion failed");

// Next-cycle implication, sampled on clk, off during rst
`define RME_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rme assertion failed");

`endif

/* rtl/core/rme_pkg.sv */
`timescale 1ns / 1ps
package rme_pkg;

  localparam int ANG_W  = 36;
  localparam int CORD_W = 56;
  localparam int CIN_W  = 30;
  localparam int SQ_N   = 29;
  localparam int SQ_IN_W = 2 * SQ_N;
  localparam int REM_W  = 33;

  localparam logic signed [ANG_W-1:0] PI_Q30      = 36'sd3373259426;
  localparam logic signed [ANG_W-1:0] HALF_PI_Q30 = 36'sd1686629713;
  localparam logic signed [15:0]      PI_Q12      = 16'sd12868;

  localparam logic [1:0] CASE_FIRST   = 2'd0;
  localparam logic [1:0] CASE_SECOND  = 2'd1;
  localparam logic [1:0] CASE_LOCK_LO = 2'd2;
  localparam logic [1:0] CASE_LOCK_HI = 2'd3;

  localparam logic REG_TOLERANCE = 1'b0;

  typedef struct packed {
    logic signed [15:0] r00;
    logic signed [15:0] r01;
    logic signed [15:0] r02;
    logic signed [15:0] r10;
    logic signed [15:0] r21;
    logic signed [15:0] r22;
    logic signed [CIN_W-1:0] sy;
    logic lock_lo;
    logic lock_hi;
  } pay_t;

  typedef struct packed {
    logic lock_lo;
    logic lock_hi;
  } flags_t;

  // arctangent of 2^-i in units of 2^-30 rad, truncated
  function automatic logic [29:0] atan_entry(input logic [4:0] i);
    logic [29:0] r;
    case (i)
      5'd0:  r = 30'd843314856;
      5'd1:  r = 30'd497837829;
      5'd2:  r = 30'd263043836;
      5'd3:  r = 30'd133525158;
      5'd4:  r = 30'd67021686;
      5'd5:  r = 30'd33543515;
      5'd6:  r = 30'd16775850;
      5'd7:  r = 30'd8388437;
      5'd8:  r = 30'd4194282;
      5'd9:  r = 30'd2097149;
      5'd10: r = 30'd1048575;
      5'd11: r = 30'd524287;
      5'd12: r = 30'd262143;
      5'd13: r = 30'd131071;
      5'd14: r = 30'd65535;
      5'd15: r = 30'd32767;
      5'd16: r = 30'd16383;
      5'd17: r = 30'd8191;
      5'd18: r = 30'd4095;
      5'd19: r = 30'd2047;
      5'd20: r = 30'd1023;
      5'd21: r = 30'd511;
      5'd22: r = 30'd255;
      5'd23: r = 30'd127;
      5'd24: r = 30'd63;
      5'd25: r = 30'd31;
      5'd26: r = 30'd15;
      5'd27: r = 30'd7;
      5'd28: r = 30'd3;
      5'd29: r = 30'd1;
      default: r = 30'd0;
    endcase
    return r;
  endfunction

  // round to Q4.12 and saturate
  function automatic logic signed [15:0] sat_q12(input logic signed [ANG_W-1:0] a);
    logic signed [ANG_W-1:0] t;
    logic signed [ANG_W-1:0] q;
    logic signed [15:0] r;
    t = a + 36'sd131072;
    q = t >>> 18;
    if (q > 36'sd32767) begin
      r = 16'sh7fff;
    end else if (q < -36'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = q[15:0];
    end
    return r;
  endfunction

endpackage

/* rtl/core/rme_sqrt.sv */
`timescale 1ns / 1ps
module rme_sqrt
  import rme_pkg::*;
(
  input  logic                clk,
  input  logic                en,
  input  logic [SQ_IN_W-1:0]  v,
  output logic [SQ_N-1:0]     root
);

  logic [REM_W-1:0]   remq  [0:SQ_N-1];
  logic [SQ_N-1:0]    rootq [0:SQ_N-1];
  logic [SQ_IN_W-1:0] vq    [0:SQ_N-1];

  // one root bit per stage, restoring digit recurrence
  for (genvar g = 0; g < SQ_N; g++) begin : g_step
    logic [REM_W-1:0]   rem_in;
    logic [SQ_N-1:0]    root_in;
    logic [SQ_IN_W-1:0] v_in;
    logic [REM_W-1:0]   cur;
    logic [REM_W-1:0]   trial;
    if (g == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign v_in    = v;
    end else begin : g_rest
      assign rem_in  = remq[g-1];
      assign root_in = rootq[g-1];
      assign v_in    = vq[g-1];
    end
    assign cur   = {rem_in[REM_W-3:0], v_in[SQ_IN_W-1 -: 2]};
    assign trial = {{(REM_W-SQ_N-2){1'b0}}, root_in, 2'b01};
    always_ff @(posedge clk) begin
      if (en) begin
        vq[g] <= {v_in[SQ_IN_W-3:0], 2'b00};
        if (cur >= trial) begin
          remq[g]  <= cur - trial;
          rootq[g] <= {root_in[SQ_N-2:0], 1'b1};
        end else begin
          remq[g]  <= cur;
          rootq[g] <= {root_in[SQ_N-2:0], 1'b0};
        end
      end
    end
  end

  assign root = rootq[SQ_N-1];

endmodule

/* rtl/core/rme_cordic.sv */
`timescale 1ns / 1ps
module rme_cordic
  import rme_pkg::*;
#(
  parameter int STAGES = 16
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [CIN_W-1:0] y_in,
  input  logic signed [CIN_W-1:0] x_in,
  output logic signed [ANG_W-1:0] z_out
);

  localparam int N = (STAGES > 32) ? 32 : STAGES;

  logic signed [CORD_W-1:0] xq [0:N];
  logic signed [CORD_W-1:0] yq [0:N];
  logic signed [ANG_W-1:0]  zq [0:N];
  logic                     zeroq [0:N];

  function automatic logic signed [CORD_W-1:0] scale(input logic signed [CIN_W-1:0] a);
    return {{(CORD_W-CIN_W-24){a[CIN_W-1]}}, a, 24'b0};
  endfunction

  // fold the left half plane and prescale
  always_ff @(posedge clk) begin
    if (en) begin
      zeroq[0] <= (x_in == '0) && (y_in == '0);
      if (x_in[CIN_W-1]) begin
        xq[0] <= scale(-x_in);
        yq[0] <= scale(-y_in);
        zq[0] <= y_in[CIN_W-1] ? -PI_Q30 : PI_Q30;
      end else begin
        xq[0] <= scale(x_in);
        yq[0] <= scale(y_in);
        zq[0] <= '0;
      end
    end
  end

  // vectoring iterations, one per stage
  for (genvar g = 0; g < N; g++) begin : g_iter
    logic signed [CORD_W-1:0] dx;
    logic signed [CORD_W-1:0] dy;
    logic signed [ANG_W-1:0]  da;
    assign dx = yq[g] >>> g;
    assign dy = xq[g] >>> g;
    assign da = $signed({{(ANG_W-30){1'b0}}, atan_entry(5'(g))});
    always_ff @(posedge clk) begin
      if (en) begin
        zeroq[g+1] <= zeroq[g];
        if (!yq[g][CORD_W-1]) begin
          xq[g+1] <= xq[g] + dx;
          yq[g+1] <= yq[g] - dy;
          zq[g+1] <= zq[g] + da;
        end else begin
          xq[g+1] <= xq[g] - dx;
          yq[g+1] <= yq[g] + dy;
          zq[g+1] <= zq[g] - da;
        end
      end
    end
  end

  assign z_out = zeroq[N] ? '0 : zq[N];

endmodule

/* rtl/core/rotation_matrix_to_euler_angles.sv */
`timescale 1ns / 1ps
// Throughput: one matrix per cycle; the square-root and CORDIC pipelines
// advance together and hold in place while a result is stalled.
// Reset (rst, synchronous): clears all valid bits and sets
// gimbal_tolerance to 16.
`include "rotation_matrix_to_euler_angles_defines.svh"
module rotation_matrix_to_euler_angles
  import rme_pkg::*;
#(
  parameter int CORDIC_STAGES = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] r00,
  input  logic signed [15:0] r01,
  input  logic signed [15:0] r02,
  input  logic signed [15:0] r10,
  input  logic signed [15:0] r20,
  input  logic signed [15:0] r21,
  input  logic signed [15:0] r22,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] angle_first,
  output logic signed [15:0] angle_second,
  output logic signed [15:0] angle_third,
  output logic [1:0]         solution_case
);

  localparam int CN    = (CORDIC_STAGES > 32) ? 32 : CORDIC_STAGES;
  localparam int VLEN  = CN + 33;
  localparam int V_A   = CN + 31;
  localparam int V_B   = CN + 32;

  logic [14:0] gimbal_tolerance;
  logic        adv;
  logic [VLEN-1:0] val_q;

  // configuration register
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_TOLERANCE) ? {17'b0, gimbal_tolerance} : 32'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      gimbal_tolerance <= 15'd16;
    end else if (psel && penable && pwrite && (paddr[2] == REG_TOLERANCE)) begin
      gimbal_tolerance <= pwdata[14:0];
    end
  end

  // whole pipeline advances unless a result is held
  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      val_q     <= '0;
      out_valid <= 1'b0;
    end else if (adv) begin
      val_q     <= {val_q[VLEN-2:0], in_valid};
      out_valid <= val_q[VLEN-1];
    end
  end

  // stage 0: lock test, clamp and radicand
  logic signed [16:0] sum_lo;
  logic signed [16:0] sum_hi;
  logic [16:0]        abs_lo;
  logic [16:0]        abs_hi;
  logic               lock_lo_c;
  logic               lock_hi_c;
  logic signed [15:0] s_cl;
  logic [31:0]        s_sq;
  logic [28:0]        w;
  pay_t               pay0;
  logic [SQ_IN_W-1:0] v0;

  assign sum_lo    = {r20[15], r20} + 17'sd16384;
  assign sum_hi    = {r20[15], r20} - 17'sd16384;
  assign abs_lo    = sum_lo[16] ? 17'(-sum_lo) : 17'(sum_lo);
  assign abs_hi    = sum_hi[16] ? 17'(-sum_hi) : 17'(sum_hi);
  assign lock_lo_c = abs_lo < {2'b0, gimbal_tolerance};
  assign lock_hi_c = !lock_lo_c && (abs_hi < {2'b0, gimbal_tolerance});
  assign s_cl      = (r20 > 16'sd16384) ? 16'sd16384 :
                     (r20 < -16'sd16384) ? -16'sd16384 : r20;
  assign s_sq      = $signed({{16{s_cl[15]}}, s_cl}) * $signed({{16{s_cl[15]}}, s_cl});
  assign w         = 29'd268435456 - s_sq[28:0];

  always_ff @(posedge clk) begin
    if (adv) begin
      pay0.r00     <= r00;
      pay0.r01     <= r01;
      pay0.r02     <= r02;
      pay0.r10     <= r10;
      pay0.r21     <= r21;
      pay0.r22     <= r22;
      pay0.sy      <= {s_cl, 14'b0};
      pay0.lock_lo <= lock_lo_c;
      pay0.lock_hi <= lock_hi_c;
      v0           <= {1'b0, w, 28'b0};
    end
  end

  // square root, with the payload delayed alongside
  logic [SQ_N-1:0] root;
  pay_t            pay_q [0:SQ_N-1];

  rme_sqrt u_sqrt (
    .clk  (clk),
    .en   (adv),
    .v    (v0),
    .root (root)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      pay_q[0] <= pay0;
      for (int i = 1; i < SQ_N; i++) begin
        pay_q[i] <= pay_q[i-1];
      end
    end
  end

  // CORDIC operands
  pay_t                   pc;
  logic signed [CIN_W-1:0] e00, e01, e02, e10, e21, e22;
  logic signed [CIN_W-1:0] za_y, za_x;
  logic signed [ANG_W-1:0] xa, ya, yb, za, zb;

  assign pc  = pay_q[SQ_N-1];
  assign e00 = CIN_W'(pc.r00);
  assign e01 = CIN_W'(pc.r01);
  assign e02 = CIN_W'(pc.r02);
  assign e10 = CIN_W'(pc.r10);
  assign e21 = CIN_W'(pc.r21);
  assign e22 = CIN_W'(pc.r22);

  always_comb begin
    if (pc.lock_lo) begin
      za_y = e01;
      za_x = e02;
    end else if (pc.lock_hi) begin
      za_y = -e01;
      za_x = -e02;
    end else begin
      za_y = e10;
      za_x = e00;
    end
  end

  rme_cordic #(.STAGES(CN)) u_cord_x (
    .clk(clk), .en(adv), .y_in(pc.sy),
    .x_in($signed({{(CIN_W-SQ_N){1'b0}}, root})), .z_out(xa));
  rme_cordic #(.STAGES(CN)) u_cord_ya (
    .clk(clk), .en(adv), .y_in(e21), .x_in(e22), .z_out(ya));
  rme_cordic #(.STAGES(CN)) u_cord_yb (
    .clk(clk), .en(adv), .y_in(-e21), .x_in(-e22), .z_out(yb));
  rme_cordic #(.STAGES(CN)) u_cord_za (
    .clk(clk), .en(adv), .y_in(za_y), .x_in(za_x), .z_out(za));
  rme_cordic #(.STAGES(CN)) u_cord_zb (
    .clk(clk), .en(adv), .y_in(-e10), .x_in(-e00), .z_out(zb));

  // lock flags follow the CORDIC latency
  flags_t fl_q [0:CN];

  always_ff @(posedge clk) begin
    if (adv) begin
      fl_q[0].lock_lo <= pc.lock_lo;
      fl_q[0].lock_hi <= pc.lock_hi;
      for (int i = 1; i <= CN; i++) begin
        fl_q[i] <= fl_q[i-1];
      end
    end
  end

  // stage A: candidates and their absolute sums
  logic signed [ANG_W-1:0] x1_c, x2_c;
  logic signed [ANG_W+1:0] sum1_c, sum2_c;

  function automatic logic signed [ANG_W+1:0] absx(input logic signed [ANG_W-1:0] a);
    return a[ANG_W-1] ? -(ANG_W+2)'(a) : (ANG_W+2)'(a);
  endfunction

  assign x1_c   = -xa;
  assign x2_c   = PI_Q30 - x1_c;
  assign sum1_c = absx(x1_c) + absx(ya) + absx(za);
  assign sum2_c = absx(x2_c) + absx(yb) + absx(zb);

  logic signed [ANG_W-1:0] a_x1, a_x2, a_y1, a_y2, a_z1, a_z2;
  logic signed [ANG_W+1:0] a_s1, a_s2;
  flags_t                  a_fl;

  always_ff @(posedge clk) begin
    if (adv) begin
      a_x1 <= x1_c;
      a_x2 <= x2_c;
      a_y1 <= ya;
      a_y2 <= yb;
      a_z1 <= za;
      a_z2 <= zb;
      a_s1 <= sum1_c;
      a_s2 <= sum2_c;
      a_fl <= fl_q[CN];
    end
  end

  // stage B: choose the solution and form the reported angles
  logic signed [ANG_W-1:0] bx, by, bz;
  logic [1:0]              bcase;
  logic signed [ANG_W-1:0] b_a1, b_a2, b_a3;
  logic [1:0]              b_case;

  always_comb begin
    if (a_fl.lock_lo) begin
      bx    = '0;
      by    = HALF_PI_Q30;
      bz    = a_z1;
      bcase = CASE_LOCK_LO;
    end else if (a_fl.lock_hi) begin
      bx    = '0;
      by    = -HALF_PI_Q30;
      bz    = a_z1;
      bcase = CASE_LOCK_HI;
    end else if (a_s1 <= a_s2) begin
      bx    = a_x1;
      by    = a_y1;
      bz    = a_z1;
      bcase = CASE_FIRST;
    end else begin
      bx    = a_x2;
      by    = a_y2;
      bz    = a_z2;
      bcase = CASE_SECOND;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_a1   <= PI_Q30 - bx;
      b_a2   <= HALF_PI_Q30 - by;
      b_a3   <= -bz;
      b_case <= bcase;
    end
  end

  // stage C: round, saturate, output register
  always_ff @(posedge clk) begin
    if (adv) begin
      angle_first   <= sat_q12(b_a1);
      angle_second  <= sat_q12(b_a2);
      angle_third   <= sat_q12(b_a3);
      solution_case <= b_case;
    end
  end

  // keep the unused stage valid taps visible to the checks below
  logic mid_busy;
  assign mid_busy = val_q[V_A] || val_q[V_B];

  `RME_ASSERT_IMPL(a_lock_lo_y, out_valid && (solution_case == CASE_LOCK_LO), angle_second == 16'sd0)
  `RME_ASSERT_IMPL(a_lock_x, out_valid && (solution_case == CASE_LOCK_LO || solution_case == CASE_LOCK_HI), angle_first == PI_Q12)
  `RME_ASSERT_IMPL(a_lock_hi_y, out_valid && (solution_case == CASE_LOCK_HI), angle_second == PI_Q12)
  `RME_ASSERT_NEXT(a_hold, out_valid && out_stall, out_valid && $stable(angle_third))
  `RME_ASSERT_NEXT(a_drain, !mid_busy && !val_q[VLEN-1] && out_valid && !out_stall, !out_valid)

endmodule
